>>> rtl/bole_pkg.sv
// Shared constants, request kinds and status codes of the ordered list engine.
`default_nettype none

package bole_pkg;

	// Storage size and derived widths
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int KIND_W   = 2;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 3;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INS_REAR  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ      = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOKEY  = 3'd3;
	localparam logic [STAT_W-1:0] ST_BADPOS = 3'd4;

	typedef logic signed [DATA_W-1:0] item_t;
	typedef logic [IDX_W-1:0]         slot_t;

endpackage

`default_nettype wire

>>> rtl/bounded_ordered_list_engine_core.sv
// Top level of the ordered list engine: request sequencer, ring pointers and result register.
//
// Holds an ordered list of up to 16 signed 32-bit items in a ring-addressed store with a
// front pointer and a count. One request word is taken at a time; in_stall stays high
// from acceptance until its result word is loaded into the output register, which may
// still be waiting on out_stall when the next request word is taken. A rejected request
// goes from acceptance straight to the done state, while an insert or a read-by-position
// first passes through its working state (S_INS or S_RDW); the done state loads the result.
// Delete-by-key walks the list through the single store read port, one item per cycle:
// it scans from the front until the key matches and then moves each later item up one
// slot. A result that waits on out_stall in the output register adds its stalled cycles
// before the next result word can be loaded. The store needs no clearing after reset;
// only reads of slots that hold live items are ever used.
`default_nettype none

module bounded_ordered_list_engine_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [bole_pkg::KIND_W-1:0]  kind,
	input  wire logic signed [31:0]           value,
	input  wire logic [bole_pkg::POS_W-1:0]   position,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [bole_pkg::STAT_W-1:0]       status,
	output logic signed [31:0]                read_data,
	output logic [bole_pkg::CNT_W-1:0]        count
);
	import bole_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_RDW   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]        state_q, state_d;
	slot_t             front_q, front_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  k_q, k_d;
	logic              res_valid_q;
	logic [KIND_W-1:0] kind_q;
	item_t             val_q;
	logic [STAT_W-1:0] status_q, status_d;
	item_t             data_q, data_d;
	logic [STAT_W-1:0] res_status_q;
	item_t             res_data_q;
	logic [CNT_W-1:0]  res_count_q;

	logic              acc;
	logic              res_load;
	logic [POS_W-1:0]  pos_m1;
	logic [CNT_W-1:0]  k_nxt;
	logic [CNT_W-1:0]  k_m1;
	slot_t             off;
	slot_t             slot;
	logic              wr_en;
	slot_t             wr_addr;
	item_t             wr_data;
	item_t             rd_q;
	logic              last;

	assign in_stall  = (state_q != S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || !out_stall);
	assign pos_m1    = position - POS_W'(1);
	assign k_nxt     = k_q + CNT_W'(1);
	assign k_m1      = k_q - CNT_W'(1);
	assign last      = (k_nxt == count_q);

	// Pick the ring offset for the shared slot adder
	always_comb begin
		case (state_q)
			S_IDLE:  off = (kind == KIND_READ) ? pos_m1[IDX_W-1:0] : '0;
			S_INS:   off = (kind_q == KIND_INS_FRONT) ? '1 : count_q[IDX_W-1:0];
			default: off = k_nxt[IDX_W-1:0];
		endcase
	end

	assign slot = front_q + off;

	// Store write: insert value, or move an item up one slot
	assign wr_en   = (state_q == S_INS) || (state_q == S_SHIFT);
	assign wr_addr = (state_q == S_INS) ? slot : (front_q + k_m1[IDX_W-1:0]);
	assign wr_data = (state_q == S_INS) ? val_q : rd_q;

	bole_store u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (slot),
		.rd_data_q (rd_q)
	);

	// Sequence one request word
	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		count_d  = count_q;
		k_d      = k_q;
		status_d = status_q;
		data_d   = data_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					status_d = ST_OK;
					data_d   = '0;
					k_d      = '0;
					case (kind)
						KIND_INS_FRONT, KIND_INS_REAR: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else begin
								state_d = S_INS;
							end
						end
						KIND_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								state_d  = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							if ((position == '0) || (CNT_W'(position) > count_q)) begin
								status_d = ST_BADPOS;
								state_d  = S_DONE;
							end else begin
								state_d = S_RDW;
							end
						end
					endcase
				end
			end
			S_INS: begin
				if (kind_q == KIND_INS_FRONT) begin
					front_d = slot;
				end
				count_d = count_q + CNT_W'(1);
				state_d = S_DONE;
			end
			S_RDW: begin
				data_d  = rd_q;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (rd_q == val_q) begin
					if (last) begin
						count_d = count_q - CNT_W'(1);
						state_d = S_DONE;
					end else begin
						k_d     = k_nxt;
						state_d = S_SHIFT;
					end
				end else if (last) begin
					status_d = ST_NOKEY;
					state_d  = S_DONE;
				end else begin
					k_d = k_nxt;
				end
			end
			S_SHIFT: begin
				if (last) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_DONE;
				end else begin
					k_d = k_nxt;
				end
			end
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			k_q     <= k_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Hold request and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= kind;
			val_q  <= value;
		end
		status_q <= status_d;
		data_q   <= data_d;
		if (res_load) begin
			res_status_q <= status_q;
			res_data_q   <= data_q;
			res_count_q  <= count_q;
		end
	end

	assign out_valid = res_valid_q;
	assign status    = res_status_q;
	assign read_data = res_data_q;
	assign count     = res_count_q;

endmodule

`default_nettype wire

>>> rtl/bole_store.sv
// Item store: one write port and one registered read port.
`default_nettype none

module bole_store (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire bole_pkg::slot_t wr_addr,
	input  wire bole_pkg::item_t wr_data,
	input  wire bole_pkg::slot_t rd_addr,
	output bole_pkg::item_t     rd_data_q
);
	import bole_pkg::*;

	item_t mem_q [CAPACITY];

	// Write one slot when enabled and register one read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the ordered list engine: directed table, then random requests.
`timescale 1ns / 100ps

module tb_top;
	import bole_pkg::*;

	localparam int RANDOM_WORDS = 600;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	// One result word as the block returns it
	typedef struct packed {
		logic [STAT_W-1:0] status;
		item_t             data;
		logic [CNT_W-1:0]  cnt;
	} result_t;

	// One row of the directed table; typed rows carry their own expected word
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		item_t             value;
		logic [POS_W-1:0]  position;
		logic              typed;
		result_t           want;
	} stim_row_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     out_stall = 1'b0;
	logic [KIND_W-1:0]        kind      = '0;
	logic signed [DATA_W-1:0] value     = '0;
	logic [POS_W-1:0]         position  = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] read_data;
	logic [CNT_W-1:0]         count;

	// Shadow copy of the list held by the block
	item_t            ring [CAPACITY];
	slot_t            ring_front = '0;
	logic [CNT_W-1:0] ring_count = '0;

	result_t pending_results [$];
	int      error_count = 0;
	int      cycle_count = 0;

	// Directed requests: empty-list errors, extremes, a wrap of the front, a full store
	stim_row_t stim_table [0:24] = '{
		'{KIND_READ,      32'sh00000000, 5'd0,  1'b1, '{ST_BADPOS, 32'sh0, 5'd0}},
		'{KIND_DELETE,    32'sh00000000, 5'd0,  1'b1, '{ST_EMPTY,  32'sh0, 5'd0}},
		'{KIND_INS_FRONT, 32'sh80000000, 5'd31, 1'b1, '{ST_OK,     32'sh0, 5'd1}},
		'{KIND_INS_REAR,  32'sh7FFFFFFF, 5'd0,  1'b1, '{ST_OK,     32'sh0, 5'd2}},
		'{KIND_READ,      32'sh00000000, 5'd1,  1'b1, '{ST_OK, 32'sh80000000, 5'd2}},
		'{KIND_READ,      32'shFFFFFFFF, 5'd31, 1'b1, '{ST_BADPOS, 32'sh0, 5'd2}},
		'{KIND_DELETE,    32'shFFFFFFFF, 5'd0,  1'b1, '{ST_NOKEY,  32'sh0, 5'd2}},
		'{KIND_INS_FRONT, 32'sh00000005, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh00000005, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'shFFFFFFFF, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh00000000, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'sh12345678, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh80000000, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'sh55555555, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'shAAAAAAAA, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'sh00000001, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh7FFFFFFE, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'sh80000001, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh00000005, 5'd0,  1'b0, '0},
		'{KIND_INS_FRONT, 32'shDEADBEEF, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh0000FFFF, 5'd0,  1'b0, '0},
		'{KIND_INS_REAR,  32'sh00000009, 5'd0,  1'b1, '{ST_FULL, 32'sh0, 5'd16}},
		'{KIND_INS_FRONT, 32'sh00000009, 5'd0,  1'b1, '{ST_FULL, 32'sh0, 5'd16}},
		'{KIND_READ,      32'sh00000000, 5'd16, 1'b0, '0},
		'{KIND_DELETE,    32'sh00000005, 5'd0,  1'b0, '0}
	};

	bounded_ordered_list_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.read_data (read_data),
		.count     (count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Give up after a generous number of cycles
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Physical slot of logical position k counted from the front
	function automatic int slot_at(input int k);
		return (int'(ring_front) + k) % CAPACITY;
	endfunction

	// Apply one request to the shadow list and return the word it should produce
	function automatic result_t list_predict(input logic [KIND_W-1:0] k, input item_t v,
			input logic [POS_W-1:0] p);
		result_t r;
		int      hit;
		r = '{ST_OK, '0, '0};
		hit = -1;
		case (k)
			KIND_INS_FRONT, KIND_INS_REAR: begin
				if (int'(ring_count) >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (k == KIND_INS_FRONT) begin
					ring_front = slot_t'((int'(ring_front) + CAPACITY - 1) % CAPACITY);
					ring[ring_front] = v;
					ring_count++;
				end else begin
					ring[slot_at(int'(ring_count))] = v;
					ring_count++;
				end
			end
			KIND_DELETE: begin
				if (ring_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first match from the front, then close the gap
					for (int i = 0; i < int'(ring_count); i++)
						if (hit < 0 && ring[slot_at(i)] == v) hit = i;
					if (hit < 0) begin
						r.status = ST_NOKEY;
					end else begin
						for (int i = hit; i + 1 < int'(ring_count); i++)
							ring[slot_at(i)] = ring[slot_at(i + 1)];
						ring_count--;
					end
				end
			end
			default: begin
				if (p == 0 || p > ring_count)
					r.status = ST_BADPOS;
				else
					r.data = ring[slot_at(int'(p) - 1)];
			end
		endcase
		r.cnt = ring_count;
		return r;
	endfunction

	// Idle cycles before the next word; every fourth stretch runs with no idling
	function automatic int wait_draw(input int seq, input int quiet_phase);
		return ((seq / 40) % 4 == quiet_phase) ? 0 : $urandom_range(0, 14);
	endfunction

	task automatic note_failure(input string msg);
		if (error_count < REPORT_MAX)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Present one request word, hold it until taken, then queue its expected result
	task automatic send_word(input logic [KIND_W-1:0] k, input item_t v,
			input logic [POS_W-1:0] p, input logic typed, input result_t want);
		result_t predicted;
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		position <= p;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = list_predict(k, v, p);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Request side
	initial begin
		logic [KIND_W-1:0] k;
		item_t             v;
		logic [POS_W-1:0]  p;
		int                sel;
		int                mode;
		int                key_share;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			send_word(stim_table[i].kind, stim_table[i].value, stim_table[i].position,
				stim_table[i].typed, stim_table[i].want);
			idle_sender(wait_draw(i, 3));
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// alternate fill, drain and balanced stretches so the count sweeps 0..16
			mode = (n / 32) % 3;
			sel = $urandom_range(0, 99);
			if (sel < (mode == 0 ? 65 : mode == 1 ? 20 : 40))
				k = $urandom_range(0, 1) ? KIND_INS_REAR : KIND_INS_FRONT;
			else if (sel < (mode == 0 ? 80 : mode == 1 ? 75 : 70))
				k = KIND_DELETE;
			else
				k = KIND_READ;

			// pick keys from live items, mostly for deletes, so deletes hit and duplicates appear
			key_share = (k == KIND_DELETE) ? 70 : 30;
			sel = $urandom_range(0, 99);
			if (sel < key_share && ring_count > 0) begin
				v = ring[slot_at($urandom_range(0, int'(ring_count) - 1))];
			end else if (sel < key_share + 15) begin
				case ($urandom_range(0, 3))
					0: v = 32'sh80000000;
					1: v = 32'sh7FFFFFFF;
					2: v = 32'sh00000000;
					default: v = 32'shFFFFFFFF;
				endcase
			end else if (sel < key_share + 35) begin
				v = $signed($urandom_range(0, 8)) - 4;
			end else begin
				v = $urandom;
			end

			sel = $urandom_range(0, 99);
			if (k == KIND_READ && sel < 70)
				p = POS_W'($urandom_range(1, int'(ring_count) + 1));
			else if (k == KIND_READ && sel < 85)
				p = '0;
			else
				p = POS_W'($urandom_range(0, 31));

			send_word(k, v, p, 1'b0, '0);
			idle_sender(wait_draw(n, 3));
		end
		in_valid <= 1'b0;

		// drain outstanding results, then let the block settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result side: stall at random, check every word taken
	initial begin
		int      n;
		int      words;
		result_t got;
		result_t want;
		words = 0;
		wait (arst_n === 1'b1);
		forever begin
			n = wait_draw(words, 1);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			words++;
			got = '{status, read_data, count};
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected word status=%0d data=%h count=%0d",
					got.status, got.data, got.cnt));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.data !== want.data
						|| got.cnt !== want.cnt)
					note_failure($sformatf(
						"word %0d: status %0d/%0d data %h/%h count %0d/%0d (exp/act)",
						words, want.status, got.status, want.data, got.data,
						want.cnt, got.cnt));
			end
		end
	end

endmodule
